// ===== rtl/mbb_pkg.sv =====
// mbb_pkg: shared types, codes and sizes of the message byte buffer
// no dependencies; imported by every module of the block
`default_nettype none

package mbb_pkg;

  // byte store size and derived memory geometry
  localparam int STORE_BYTES = 2048;
  localparam int LANES       = 4;
  localparam int ADDR_W      = ($clog2(STORE_BYTES) < 3) ? 3 : $clog2(STORE_BYTES);
  localparam int ROW_W       = ADDR_W - 2;
  localparam int BANK_DEPTH  = (STORE_BYTES + LANES - 1) / LANES;

  // cursor and register widths follow the field widths
  localparam int CUR_W     = 12;
  localparam int RCUR_W    = CUR_W + 1;
  localparam int CAP_LIMIT = (STORE_BYTES > 4095) ? 4095 : STORE_BYTES;

  // configuration register indexes
  localparam logic [1:0] REG_BUFFER_SIZE     = 2'd0;
  localparam logic [1:0] REG_ALLOW_OVERFLOW  = 2'd1;
  localparam logic [1:0] REG_ALLOW_UNDERFLOW = 2'd2;

  // action codes
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_WR8   = 3'd1;
  localparam logic [2:0] ACT_WR16  = 3'd2;
  localparam logic [2:0] ACT_WR32  = 3'd3;
  localparam logic [2:0] ACT_RD8   = 3'd4;
  localparam logic [2:0] ACT_RD16S = 3'd5;
  localparam logic [2:0] ACT_RD16U = 3'd6;
  localparam logic [2:0] ACT_RD32  = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_WRAPPED         = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE       = 3'd2;
  localparam logic [2:0] ST_OVERFLOW_DENIED = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW       = 3'd4;
  localparam logic [2:0] ST_UNDERFLOW_DENIED = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] write_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [2:0]         status;
    logic               overflowed_flag;
    logic [CUR_W-1:0]   bytes_used;
  } result_t;

  // one access to the banked store; byte_en lane i is byte i of the word
  typedef struct packed {
    logic              wr;
    logic [LANES-1:0]  byte_en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/mbb_store.sv =====
// mbb_store: byte store split into four byte-wide banks, one word access per cycle
// depends on mbb_pkg for geometry and the request struct
`default_nettype none

module mbb_store (
  input  wire logic              clk,
  input  wire mbb_pkg::mem_req_t req,
  output logic [31:0]            rdata
);
  import mbb_pkg::*;

  logic [7:0] bank_q [LANES];
  logic [1:0] lo_q;

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [7:0]        bank_mem [BANK_DEPTH];
    logic [1:0]        lane;
    logic [ADDR_W-1:0] byte_addr;
    logic [ROW_W-1:0]  row;

    // which byte of the word lands in this bank
    assign lane      = 2'(b) - req.addr[1:0];
    assign byte_addr = req.addr + ADDR_W'(lane);
    assign row       = byte_addr[ADDR_W-1:2];

    always_ff @(posedge clk) begin
      if (req.wr && req.byte_en[lane]) begin
        bank_mem[row] <= req.wdata[8*lane +: 8];
      end
      bank_q[b] <= bank_mem[row];
    end
  end

  always_ff @(posedge clk) begin
    lo_q <= req.addr[1:0];
  end

  // rotate bank outputs back into word byte order
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rdata[8*i +: 8] = bank_q[2'(lo_q + 2'(i))];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/message_byte_buffer.sv =====
// message_byte_buffer: top level, cursors, error checks, config registers, result formatting
// depends on mbb_pkg and mbb_store
`default_nettype none

// Message byte buffer. Each command word (clear, append 8/16/32 bits, or consume
// 8/16/32 bits, all little endian) is taken when start is high and busy is low.
// For every command, at the accepting edge the checks run, the
// cursors update and the one banked store access (write of up to four bytes, or
// read of up to four bytes) is issued; at the following edge the result word is
// registered from the read data of the synchronous store. The result sits on
// result for exactly one cycle while done is high, and busy is low in that same
// cycle, so a new command may be accepted while a result is shown. The receiver cannot
// stall the block: a result must be taken in the cycle it is shown. Because each
// command finishes its store access before the next can be accepted, a read
// always sees the bytes of every earlier write. Configuration writes (cfg_ready is
// always high) belong between commands, while busy is low. The store has no reset
// and no clearing pass; reads only reach bytes written since the last clear.
module message_byte_buffer (
  input  wire logic             clk,
  input  wire logic             rst,
  // command channel
  input  wire logic             start,
  input  wire mbb_pkg::item_t   item,
  output logic                  busy,
  // result channel
  output logic                  done,
  output mbb_pkg::result_t      result,
  // configuration write channel
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [11:0]      cfg_data
);
  import mbb_pkg::*;

  // configuration registers
  logic [CUR_W-1:0] buffer_size;
  logic             allow_overflow;
  logic             allow_underflow;

  // buffer state
  logic [CUR_W-1:0]  wcur;
  logic [RCUR_W-1:0] rcur;
  logic              ov_mark;

  // command held between the accepting edge and the result edge
  logic [2:0] act_q;
  logic [2:0] status_q;

  logic             accept;
  logic [CUR_W-1:0] cap;
  logic [CUR_W-1:0] room;
  logic [2:0]       wr_len;
  logic [2:0]       rd_len;
  logic [2:0]       wr_status;
  logic             wr_go;
  logic [CUR_W-1:0] wr_base;
  logic [RCUR_W-1:0] wcur_ext;
  logic             rd_short;
  logic [2:0]       item_status;
  logic [LANES-1:0] lane_mask;
  mem_req_t         mem_req;
  logic [31:0]      mem_rdata;
  logic [31:0]      rd_value;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // capacity is the programmed size limited to the physical store
  assign cap  = (buffer_size > CUR_W'(CAP_LIMIT)) ? CUR_W'(CAP_LIMIT) : buffer_size;
  assign room = cap - wcur;

  always_comb begin
    case (item.action)
      ACT_WR8:  wr_len = 3'd1;
      ACT_WR16: wr_len = 3'd2;
      default:  wr_len = 3'd4;
    endcase
    case (item.action)
      ACT_RD8:  rd_len = 3'd1;
      ACT_RD32: rd_len = 3'd4;
      default:  rd_len = 3'd2;
    endcase
  end

  // write checks: cursor past a lowered capacity, no room, or wrap to zero
  always_comb begin
    if (wcur > cap) begin
      wr_status = ST_OVERFLOW_DENIED;
    end else if (CUR_W'(wr_len) > room) begin
      if (CUR_W'(wr_len) > cap) begin
        wr_status = ST_TOO_LARGE;
      end else if (!allow_overflow) begin
        wr_status = ST_OVERFLOW_DENIED;
      end else begin
        wr_status = ST_WRAPPED;
      end
    end else begin
      wr_status = ST_OK;
    end
  end

  assign wr_go   = (wr_status == ST_OK) || (wr_status == ST_WRAPPED);
  assign wr_base = (wr_status == ST_WRAPPED) ? '0 : wcur;

  // read check; the read cursor may sit one past the write cursor
  assign wcur_ext = RCUR_W'(wcur);
  assign rd_short = (rcur > wcur_ext) || (RCUR_W'(rd_len) > (wcur_ext - rcur));

  always_comb begin
    unique case (item.action) inside
      ACT_CLEAR: item_status = ST_OK;
      ACT_WR8, ACT_WR16, ACT_WR32: item_status = wr_status;
      default: begin
        if (!rd_short) begin
          item_status = ST_OK;
        end else if (allow_underflow) begin
          item_status = ST_UNDERFLOW;
        end else begin
          item_status = ST_UNDERFLOW_DENIED;
        end
      end
    endcase
  end

  // byte lanes touched by this command
  always_comb begin
    lane_mask = '0;
    for (int i = 0; i < LANES; i++) begin
      if (item.action[2]) begin
        lane_mask[i] = 3'(i) < rd_len;
      end else begin
        lane_mask[i] = 3'(i) < wr_len;
      end
    end
  end

  // one store access per command, issued at the accepting edge
  always_comb begin
    mem_req.wr      = accept && !item.action[2] && (item.action != ACT_CLEAR) && wr_go;
    mem_req.byte_en = lane_mask;
    mem_req.addr    = item.action[2] ? ADDR_W'(rcur) : ADDR_W'(wr_base);
    mem_req.wdata   = item.write_value;
  end

  mbb_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size     <= CUR_W'(2048);
      allow_overflow  <= 1'b1;
      allow_underflow <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUFFER_SIZE:     buffer_size     <= cfg_data;
        REG_ALLOW_OVERFLOW:  allow_overflow  <= cfg_data[0];
        REG_ALLOW_UNDERFLOW: allow_underflow <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // cursors and overflow mark change only at the accepting edge
  always_ff @(posedge clk) begin
    if (rst) begin
      wcur    <= '0;
      rcur    <= '0;
      ov_mark <= 1'b0;
    end else if (accept) begin
      unique case (item.action) inside
        ACT_CLEAR: begin
          wcur    <= '0;
          rcur    <= '0;
          ov_mark <= 1'b0;
        end
        ACT_WR8, ACT_WR16, ACT_WR32: begin
          if (wr_go) begin
            wcur <= wr_base + CUR_W'(wr_len);
          end
          if (wr_status == ST_WRAPPED) begin
            rcur    <= '0;
            ov_mark <= 1'b1;
          end
        end
        default: begin
          if (!rd_short) begin
            rcur <= rcur + RCUR_W'(rd_len);
          end else if (allow_underflow) begin
            // park past the data so later reads also underflow until writes move the write cursor past it
            rcur <= wcur_ext + RCUR_W'(1);
          end
        end
      endcase
    end
  end

  // handshake: busy for the one cycle the store read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= accept;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= item.action;
      status_q <= item_status;
    end
  end

  // format the read word; the store hands bytes back in word order
  always_comb begin
    case (act_q)
      ACT_RD8:   rd_value = {24'd0, mem_rdata[7:0]};
      ACT_RD16S: rd_value = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
      ACT_RD16U: rd_value = {16'd0, mem_rdata[15:0]};
      default:   rd_value = mem_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (act_q[2] && (status_q == ST_OK)) begin
        result.read_value <= rd_value;
      end else if (status_q == ST_UNDERFLOW) begin
        result.read_value <= '1;
      end else begin
        result.read_value <= '0;
      end
      result.status          <= status_q;
      result.overflowed_flag <= ov_mark;
      result.bytes_used      <= wcur;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbb_checker.sv =====
// mbb_checker: port-level assertions on the message byte buffer, bound to the top level
// depends on mbb_pkg and message_byte_buffer
`default_nettype none

module mbb_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire mbb_pkg::result_t result
);
  import mbb_pkg::*;

  // an accepted word raises busy, then yields exactly one result as busy drops
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy did not end in a result");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an accepted word");

  // underflow always reads as all ones
  a_underflow_value: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_UNDERFLOW)) |-> (result.read_value == -32'sd1))
    else $error("underflow result is not -1");

  // denied, too-large and wrapped results carry a zero value
  a_error_value: assert property (@(posedge clk) disable iff (rst)
    (done && ((result.status == ST_TOO_LARGE) || (result.status == ST_OVERFLOW_DENIED)
      || (result.status == ST_UNDERFLOW_DENIED) || (result.status == ST_WRAPPED)))
      |-> (result.read_value == 32'sd0))
    else $error("error result carries a value");

endmodule

bind message_byte_buffer mbb_checker u_mbb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== tb/sv/message_byte_buffer_test.sv =====
// message_byte_buffer_test: self-checking bench for the message byte buffer
// depends on mbb_pkg and message_byte_buffer; mirrors cursors, store and registers
`timescale 1ns / 100ps

module message_byte_buffer_test;
  import mbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  // mirror of the buffer: byte store, cursors, sticky mark and registers
  class buffer_mirror;
    logic [7:0]  store_bytes [STORE_BYTES];
    int unsigned wr_cur = 0;
    int unsigned rd_cur = 0;
    bit          wrap_mark = 1'b0;
    int unsigned size_reg = 2048;
    bit          overflow_ok = 1'b1;
    bit          underflow_ok = 1'b1;
    result_t     awaited[$];
    int          mismatches = 0;

    function void write_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        REG_BUFFER_SIZE:     size_reg = 32'(data);
        REG_ALLOW_OVERFLOW:  overflow_ok = data[0];
        REG_ALLOW_UNDERFLOW: underflow_ok = data[0];
        default: ;
      endcase
    endfunction

    function int awaited_count();
      return awaited.size();
    endfunction

    // works out the result word of one accepted command
    function void log_command(item_t cmd);
      result_t     r;
      int unsigned cap;
      int unsigned len;
      int unsigned i;
      logic [31:0] raw;
      r = '0;
      r.status = ST_OK;
      case (cmd.action)
        ACT_CLEAR: begin
          wr_cur = 0;
          rd_cur = 0;
          wrap_mark = 1'b0;
        end
        ACT_WR8, ACT_WR16, ACT_WR32: begin
          cap = (size_reg > STORE_BYTES) ? STORE_BYTES : size_reg;
          len = (cmd.action == ACT_WR8) ? 1 : ((cmd.action == ACT_WR16) ? 2 : 4);
          if (wr_cur > cap) begin
            r.status = ST_OVERFLOW_DENIED;
          end else if (len > cap - wr_cur) begin
            if (len > cap) begin
              r.status = ST_TOO_LARGE;
            end else if (!overflow_ok) begin
              r.status = ST_OVERFLOW_DENIED;
            end else begin
              wr_cur = 0;
              rd_cur = 0;
              wrap_mark = 1'b1;
              r.status = ST_WRAPPED;
            end
          end
          if (r.status == ST_OK || r.status == ST_WRAPPED) begin
            for (i = 0; i < len; i++)
              if (wr_cur + i < STORE_BYTES)
                store_bytes[ADDR_W'(wr_cur + i)] = cmd.write_value[8*i +: 8];
            wr_cur += len;
          end
        end
        default: begin
          len = (cmd.action == ACT_RD8) ? 1 : ((cmd.action == ACT_RD32) ? 4 : 2);
          if (rd_cur > wr_cur || len > wr_cur - rd_cur) begin
            if (!underflow_ok) begin
              r.status = ST_UNDERFLOW_DENIED;
            end else begin
              rd_cur = wr_cur + 1;
              r.read_value = '1;
              r.status = ST_UNDERFLOW;
            end
          end else begin
            raw = '0;
            for (i = 0; i < len; i++) raw[8*i +: 8] = store_bytes[ADDR_W'(rd_cur + i)];
            rd_cur += len;
            if (cmd.action == ACT_RD16S) raw[31:16] = {16{raw[15]}};
            r.read_value = raw;
          end
        end
      endcase
      r.overflowed_flag = wrap_mark;
      r.bytes_used = wr_cur[11:0];
      awaited.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word %h with nothing awaited", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.overflowed_flag !== want.overflowed_flag || got.bytes_used !== want.bytes_used) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp/act read_value %h/%h status %0d/%0d flag %0d/%0d used %0d/%0d",
                   $time, want.read_value, got.read_value, want.status, got.status,
                   want.overflowed_flag, got.overflowed_flag, want.bytes_used, got.bytes_used);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  item_t       item = '0;
  logic        busy;
  logic        done;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  buffer_mirror mirror = new();
  int           sent_count = 0;
  int           burst_left = 0;
  int           quiet_cycles = 0;

  message_byte_buffer u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // monitor: everything sampled at the rising edge, before this edge's updates land
  always @(posedge clk) begin
    if (!rst) begin
      // result word shown for one cycle only, taken at the edge that ends it
      if (done) mirror.check_result(result);
      if (start && !busy) mirror.log_command(item);
      if (cfg_valid && cfg_ready) mirror.write_reg(cfg_index, cfg_data);
      // watchdog: any handshake counts as progress
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic item_t cmd(logic [2:0] act, logic [31:0] value);
    item_t it;
    it.action = act;
    it.write_value = value;
    return it;
  endfunction

  // data word with a bias toward the extremes and the rd16 sign bit
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'h0000_8000 | ($urandom & 32'hffff_7fff);
      default: return $urandom;
    endcase
  endfunction

  // one command word; bursts of random length with random gaps in front
  task automatic send_command(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // start stays high from word to word inside a burst
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers only change with the block idle and every result word in
  task automatic program_registers(input logic [11:0] size, input bit ovf, input bit unf);
    logic [10:0] junk;
    start <= 1'b0;
    @(posedge clk);
    while (mirror.awaited_count() != 0) @(posedge clk);
    write_reg(REG_BUFFER_SIZE, size);
    // upper bits of the flag words must be ignored
    junk = 11'($urandom);
    write_reg(REG_ALLOW_OVERFLOW, {junk, ovf});
    junk = 11'($urandom);
    write_reg(REG_ALLOW_UNDERFLOW, {junk, unf});
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  // a few writes of random width, read back with matching widths
  task automatic send_message();
    logic [2:0] widths [6];
    logic [2:0] rd;
    int         n;
    int         k;
    if ($urandom_range(0, 3) == 0) send_command(cmd(ACT_CLEAR, $urandom));
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      widths[k] = 3'($urandom_range(ACT_WR8, ACT_WR32));
      send_command(cmd(widths[k], pick_value()));
    end
    for (k = 0; k < n; k++) begin
      case (widths[k])
        ACT_WR8:  rd = ACT_RD8;
        ACT_WR16: rd = $urandom_range(0, 1) ? ACT_RD16S : ACT_RD16U;
        default:  rd = ACT_RD32;
      endcase
      send_command(cmd(rd, $urandom));
    end
    // sometimes one read too many, to run into underflow
    if ($urandom_range(0, 4) == 0)
      send_command(cmd(3'($urandom_range(ACT_RD8, ACT_RD32)), $urandom));
  endtask

  task automatic program_random_registers();
    logic [11:0] size;
    case ($urandom_range(0, 11))
      0: size = 12'd0;
      1: size = 12'd1;
      2: size = 12'd4;
      3: size = 12'd2047;
      4: size = 12'd2048;
      5: size = 12'hfff;
      6: size = 12'($urandom_range(2049, 4094));
      default: size = 12'($urandom_range(2, 40));
    endcase
    program_registers(size, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    int phase;
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full store, overflow and underflow allowed
    send_command(cmd(ACT_RD8, 32'h0));          // read of an empty store
    send_command(cmd(ACT_CLEAR, 32'hffff_ffff));
    send_command(cmd(ACT_WR8, 32'hffff_ffff));
    send_command(cmd(ACT_WR16, 32'h1234_8000));
    send_command(cmd(ACT_WR32, 32'h8000_0000));
    send_command(cmd(ACT_WR16, 32'h0000_7fff));
    send_command(cmd(ACT_WR32, 32'h0000_0000));
    send_command(cmd(ACT_RD8, 32'h0));
    send_command(cmd(ACT_RD16S, 32'h0));        // negative half word
    send_command(cmd(ACT_RD32, 32'h0));
    send_command(cmd(ACT_RD16U, 32'h0));
    send_command(cmd(ACT_RD32, 32'h0));
    send_command(cmd(ACT_RD16U, 32'h0));        // short read, cursor parked past data
    send_command(cmd(ACT_RD32, 32'h0));         // read cursor already past write cursor
    send_command(cmd(ACT_WR16, 32'h0000_a5c3));
    send_command(cmd(ACT_RD8, 32'h0));

    // capacity below the write cursor, then no overflow and no underflow
    program_registers(12'd4, 1'b0, 1'b0);
    send_command(cmd(ACT_WR8, 32'h11));
    send_command(cmd(ACT_CLEAR, 32'h0));
    send_command(cmd(ACT_WR32, 32'hdead_beef));
    send_command(cmd(ACT_WR8, 32'h22));         // does not fit, overflow not allowed
    send_command(cmd(ACT_RD16S, 32'h0));
    send_command(cmd(ACT_RD16U, 32'h0));
    send_command(cmd(ACT_RD8, 32'h0));          // underflow not allowed

    // write wider than the capacity, then a wrap
    program_registers(12'd2, 1'b1, 1'b1);
    send_command(cmd(ACT_CLEAR, 32'h0));
    send_command(cmd(ACT_WR32, 32'h0102_0304));
    send_command(cmd(ACT_WR16, 32'h0000_5566));
    send_command(cmd(ACT_WR8, 32'h77));

    // zero capacity
    program_registers(12'd0, 1'b1, 1'b1);
    send_command(cmd(ACT_CLEAR, 32'h0));
    send_command(cmd(ACT_WR8, 32'h33));

    // random phases, each with its own register settings
    for (phase = 0; phase < 12; phase++) begin
      program_random_registers();
      target = sent_count + 70;
      while (sent_count < target) begin
        if ($urandom_range(0, 4) == 0) send_command(cmd(3'($urandom_range(0, 7)), pick_value()));
        else send_message();
      end
    end

    // fill the whole store with an out-of-range size until it wraps
    program_registers(12'hfff, 1'b1, 1'b1);
    send_command(cmd(ACT_CLEAR, 32'h0));
    target = sent_count + 560;
    while (sent_count < target) begin
      if ($urandom_range(0, 15) == 0) send_command(cmd(3'($urandom_range(1, 7)), pick_value()));
      else send_command(cmd(ACT_WR32, pick_value()));
    end

    // drain, then a few cycles for any stray result word
    start <= 1'b0;
    @(posedge clk);
    while (mirror.awaited_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.awaited_count() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
